>>> sv/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the multilevel priority FIFO unit.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int CMD_W    = 2;
  localparam int LEVEL_W  = 3;
  localparam int VALUE_W  = 16;
  localparam int HEAD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP_TOP = 2'd1,
    CMD_POP_LVL = 2'd2,
    CMD_STATUS  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_HEAD = 2'd2,
    S_RESP = 2'd3
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming command
    logic exec;     // pointer/count update, entry write
    logic head_rd;  // look up new top level, read its head entry
    logic resp;     // result on the ports
  } ctl_t;

endpackage

>>> sv/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-port RAM, one address per cycle, registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Command sequencer: capture, update, head lookup, result strobe.
// ----------------------------------------------------------------------------
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output ctl_t ctl_o
);

  state_e state_q, state_d;
  logic   accept;

  // a new command may enter while the previous result is shown
  assign busy_o = (state_q == S_EXEC) || (state_q == S_HEAD);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_HEAD;
      S_HEAD: state_d = S_RESP;
      S_RESP: begin
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.capture = accept;
    unique case (state_q)
      S_EXEC:  ctl_o.exec    = 1'b1;
      S_HEAD:  ctl_o.head_rd = 1'b1;
      S_RESP:  ctl_o.resp    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp
// Datapath: per-level pointers and counts, entry RAM, top-level encoder.
// ----------------------------------------------------------------------------
module mpq_dp
  import mpq_pkg::*;
#(
  parameter int MAX_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [LEVEL_W-1:0]  level_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic [HEAD_W-1:0]   head_id_o,
  output logic                head_valid_o,
  output logic                all_empty_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LVL_X   = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;
  localparam int PTR_W   = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int CMP_W0  = $clog2(MAX_LEVELS + 1);
  localparam int CMP_W   = (CMP_W0 > CFG_W) ? CMP_W0 : CFG_W;
  localparam int RAM_D   = MAX_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(RAM_D);

  logic [CFG_W-1:0]   active_q;
  cmd_e               cmd_q;
  logic [LEVEL_W-1:0] level_q;
  logic [VALUE_W-1:0] value_q;
  status_e            status_q, status_d;
  logic               found_q;

  logic [PTR_W-1:0] rd_q  [MAX_LEVELS];
  logic [PTR_W-1:0] rd_d  [MAX_LEVELS];
  logic [PTR_W-1:0] wr_q  [MAX_LEVELS];
  logic [PTR_W-1:0] wr_d  [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_q [MAX_LEVELS];
  logic [CNT_W-1:0] cnt_d [MAX_LEVELS];

  logic [CMP_W-1:0] eff;
  logic [LVL_X-1:0] lvl_ext;
  logic             in_range;
  logic [LVL_W-1:0] top;
  logic             found;
  logic [LVL_W-1:0] sel;
  logic [PTR_W-1:0] sel_rd, sel_wr, top_rd;
  logic [CNT_W-1:0] sel_cnt;
  logic             do_push, do_pop;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ID_BITS-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // effective active count, saturated at MAX_LEVELS
  always_comb begin
    if (CMP_W'(active_q) > CMP_W'(MAX_LEVELS)) eff = CMP_W'(MAX_LEVELS);
    else                                       eff = CMP_W'(active_q);
  end

  assign lvl_ext  = LVL_X'(level_q);
  assign in_range = CMP_W'(level_q) < eff;

  // highest active level holding an entry
  always_comb begin
    top   = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if ((cnt_q[i] != '0) && (CMP_W'(i) < eff)) begin
        top   = LVL_W'(i);
        found = 1'b1;
      end
    end
  end

  assign sel     = (cmd_q == CMD_POP_TOP) ? top : lvl_ext[LVL_W-1:0];
  assign sel_rd  = rd_q[sel];
  assign sel_wr  = wr_q[sel];
  assign sel_cnt = cnt_q[sel];
  assign top_rd  = rd_q[top];

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    status_d = ST_OK;
    case (cmd_q)
      CMD_PUSH: begin
        if (!in_range)                              status_d = ST_RANGE;
        else if (sel_cnt == CNT_W'(LEVEL_DEPTH))    status_d = ST_FULL;
        else                                        do_push  = 1'b1;
      end
      CMD_POP_TOP: do_pop = found;
      CMD_POP_LVL: begin
        if (!in_range) status_d = ST_RANGE;
        else           do_pop   = (sel_cnt != '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (ctl_i.exec && do_push) begin
      wr_d[sel]  = next_ptr(sel_wr);
      cnt_d[sel] = sel_cnt + CNT_W'(1);
    end
    if (ctl_i.exec && do_pop) begin
      rd_d[sel]  = next_ptr(sel_rd);
      cnt_d[sel] = sel_cnt - CNT_W'(1);
    end
  end

  // write during update, head read in the following cycle
  assign ram_we = ctl_i.exec && do_push;
  always_comb begin
    if (ctl_i.head_rd) ram_addr = ADDR_W'(top * LEVEL_DEPTH) + ADDR_W'(top_rd);
    else               ram_addr = ADDR_W'(sel * LEVEL_DEPTH) + ADDR_W'(sel_wr);
  end

  mpq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ID_BITS'(value_q)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CFG_RESET;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        rd_q[i]  <= '0;
        wr_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) active_q <= cfg_wdata_i;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= cmd_e'(cmd_i);
      level_q <= level_i;
      value_q <= value_i;
    end
    if (ctl_i.exec)    status_q <= status_d;
    if (ctl_i.head_rd) found_q  <= found;
  end

  assign head_id_o    = found_q ? HEAD_W'(ram_rdata) : '0;
  assign head_valid_o = found_q;
  assign all_empty_o  = !found_q;
  assign status_o     = status_q;

endmodule

>>> sv/multilevel_priority_fifo_unit.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_unit
// Strict-priority ready queue, one circular FIFO per level in a shared RAM.
// ----------------------------------------------------------------------------
// Sequence: an accepted command passes the pointer update state and the
//   registered RAM read of the new head, then done_o pulses; a new command
//   may be taken while the result is shown.
// Reset: async, clears pointers and counts, active_levels = 6. Entry RAM is
//   not cleared. The receiver cannot stall; each result shows for one cycle.
module multilevel_priority_fifo_unit
  import mpq_pkg::*;
#(
  parameter int MAX_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [LEVEL_W-1:0]  level_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                done_o,
  output logic [HEAD_W-1:0]   head_id_o,
  output logic                head_valid_o,
  output logic                all_empty_o,
  output logic [STATUS_W-1:0] status_o
);

  ctl_t ctl;

  mpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .ctl_o   (ctl)
  );

  mpq_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (cmd_i),
    .level_i      (level_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_id_o    (head_id_o),
    .head_valid_o (head_valid_o),
    .all_empty_o  (all_empty_o),
    .status_o     (status_o)
  );

  assign done_o = ctl.resp;

endmodule

>>> sv/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks for the multilevel priority FIFO unit.
// ----------------------------------------------------------------------------
module mpq_checker
  import mpq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [HEAD_W-1:0]   head_id_o,
  input logic                head_valid_o,
  input logic                all_empty_o,
  input logic [STATUS_W-1:0] status_o
);

  // every accepted transaction returns its result strobe on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after accept");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (head_valid_o != all_empty_o)
               && (head_valid_o || head_id_o == '0))
    else $error("head_valid, all_empty and head_id disagree");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_RANGE))
    else $error("undefined status code");

endmodule

bind multilevel_priority_fifo_unit mpq_checker u_mpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .head_id_o    (head_id_o),
  .head_valid_o (head_valid_o),
  .all_empty_o  (all_empty_o),
  .status_o     (status_o)
);
